@@ rtl/u2l_pkg.sv @@
// Shared types, constants and character mapping functions for the UTF-8 converter.
package u2l_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] PL_NONE = 2'd0;
  localparam logic [1:0] PL_C2   = 2'd1;
  localparam logic [1:0] PL_C3   = 2'd2;

  localparam logic [7:0] LEAD_C2 = 8'hC2;
  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [7:0] QM      = 8'h3F;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  typedef struct packed {
    logic [7:0] char_val;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]        len;
    result_t [2:0]     res;
  } entry_t;

  function automatic logic [7:0] c3_map(input logic [5:0] idx);
    logic [7:0] up;
    case (idx[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: up = "A";
      5'd7: up = "C";
      5'd8, 5'd9, 5'd10, 5'd11: up = "E";
      5'd12, 5'd13, 5'd14, 5'd15: up = "I";
      5'd17: up = "N";
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24: up = "O";
      5'd25, 5'd26, 5'd27, 5'd28: up = "U";
      5'd29: up = "Y";
      default: up = QM;
    endcase
    if (idx == 6'd63) begin
      return "y";
    end else if (idx[5] && up != QM) begin
      return up | 8'h20;
    end
    return up;
  endfunction

  function automatic logic [7:0] ascii_map(input logic [1:0] lead, input logic [7:0] b);
    logic [7:0] ch;
    if (lead == PL_C3) begin
      ch = (b[7:6] == 2'b10) ? c3_map(b[5:0]) : QM;
    end else begin
      case (b)
        8'hA9: ch = "C";
        8'hAE: ch = "R";
        8'hB0: ch = "o";
        8'hB1: ch = "+";
        8'hB2: ch = "2";
        8'hB3: ch = "3";
        default: ch = QM;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] latin_map(input logic [1:0] lead, input logic [7:0] b);
    return {1'b1, (lead == PL_C3), b[5:0]};
  endfunction

endpackage

@@ rtl/u2l_front.sv @@
// Front end: decodes each byte, tracks lead/skip/count state, builds a queue entry.
module u2l_front import u2l_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  input  logic        mode,
  input  logic [15:0] capacity,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [1:0]  pend, pend_next;
  logic        skip, skip_next;
  logic [15:0] count, count_next;

  logic [7:0]  cands [2];
  logic [1:0]  nc;
  logic        term;
  logic        cont;
  logic        done;
  logic [15:0] capm1;
  logic        e_a, e_b;
  logic [1:0]  k;

  always_comb begin
    cont = (data_byte[7:6] == 2'b10);
    pend_next = pend;
    skip_next = skip;
    nc = 2'd0;
    cands[0] = 8'h00;
    cands[1] = 8'h00;
    term = 1'b0;
    done = 1'b0;
    if (data_byte == 8'h00) begin
      if (pend != PL_NONE) begin
        cands[nc[0]] = QM;
        nc = nc + 2'd1;
      end
      term = 1'b1;
    end else if (!mode) begin
      skip_next = 1'b0;
      if (pend != PL_NONE) begin
        cands[nc[0]] = ascii_map(pend, data_byte);
        nc = nc + 2'd1;
        pend_next = PL_NONE;
      end else if (!data_byte[7]) begin
        cands[nc[0]] = data_byte;
        nc = nc + 2'd1;
      end else if (data_byte == LEAD_C2) begin
        pend_next = PL_C2;
      end else if (data_byte == LEAD_C3) begin
        pend_next = PL_C3;
      end else begin
        cands[nc[0]] = QM;
        nc = nc + 2'd1;
      end
    end else begin
      if (pend != PL_NONE) begin
        pend_next = PL_NONE;
        if (cont) begin
          cands[nc[0]] = latin_map(pend, data_byte);
          nc = nc + 2'd1;
          done = 1'b1;
        end else begin
          cands[nc[0]] = QM;
          nc = nc + 2'd1;
        end
      end
      if (!done && !(skip && cont)) begin
        skip_next = 1'b0;
        if (!data_byte[7]) begin
          cands[nc[0]] = data_byte;
          nc = nc + 2'd1;
        end else if (data_byte == LEAD_C2) begin
          pend_next = PL_C2;
        end else if (data_byte == LEAD_C3) begin
          pend_next = PL_C3;
        end else begin
          skip_next = 1'b1;
          cands[nc[0]] = QM;
          nc = nc + 2'd1;
        end
      end
    end
    if (data_byte != 8'h00 && string_end) begin
      if (pend_next != PL_NONE) begin
        cands[nc[0]] = QM;
        nc = nc + 2'd1;
      end
      term = 1'b1;
    end
    if (term) begin
      pend_next = PL_NONE;
      skip_next = 1'b0;
    end
  end

  // capacity counts the terminator; zero behaves as one
  assign capm1 = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
  assign e_a = (nc != 2'd0) && ({1'b0, count} < {1'b0, capm1});
  assign e_b = (nc == 2'd2) && (({1'b0, count} + 17'd1) < {1'b0, capm1});
  assign k = {1'b0, e_a} + {1'b0, e_b};

  always_comb begin
    q_entry.res[0] = '{char_val: cands[0], last: 1'b0};
    q_entry.res[1] = '{char_val: cands[1], last: 1'b0};
    q_entry.res[2] = '{char_val: 8'h00, last: 1'b1};
    if (term) begin
      q_entry.res[k] = '{char_val: 8'h00, last: 1'b1};
    end
    q_entry.len = k + {1'b0, term};
    count_next = term ? 16'd0 : count + {14'd0, k};
  end

  assign q_push = accept && (q_entry.len != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= PL_NONE;
      skip  <= 1'b0;
      count <= 16'd0;
    end else if (accept) begin
      pend  <= pend_next;
      skip  <= skip_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/u2l_fifo.sv @@
// Short queue of decoded entries between the front end and the output stage.
module u2l_fifo import u2l_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   full,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ rtl/u2l_back.sv @@
// Output stage: walks the results of the head entry, one per transaction.
module u2l_back import u2l_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic [1:0] idx;
  logic       take;
  logic       at_end;

  assign empty    = q_empty;
  assign out_char = head.res[idx].char_val;
  assign out_last = head.res[idx].last;
  assign take     = pop && !q_empty;
  assign at_end   = (idx == head.len - 2'd1);
  assign q_pop    = take && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

@@ rtl/utf8_to_latin1_or_ascii_core.sv @@
// UTF-8 to ASCII/Latin-1 converter top level: config registers, front end, queue, output.
// An accepted byte's entry is registered in the queue; outputs are read from its head.
// Throughput: one input byte per cycle while the entry queue has room.
// Output: one result per cycle while not empty; an entry is popped after its last result.
// Reset (rst, synchronous): clears decode state, queue and registers (mode 0, capacity 64).
module utf8_to_latin1_or_ascii_core import u2l_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        conversion_mode;
  logic [15:0] out_capacity;
  logic        accept;
  logic        q_push, q_pop, q_empty;
  entry_t      q_entry, head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= 1'b0;
      out_capacity    <= 16'd64;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_MODE: conversion_mode <= pwdata[0];
        REG_CAP:  out_capacity    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {31'd0, conversion_mode};
      REG_CAP:  prdata = {16'd0, out_capacity};
      default:  prdata = 32'd0;
    endcase
  end

  assign accept = push && !full;

  u2l_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .string_end (string_end),
    .mode       (conversion_mode),
    .capacity   (out_capacity),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  u2l_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .rd_entry (head),
    .full     (full),
    .empty    (q_empty)
  );

  u2l_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .out_last (out_last)
  );

`ifndef SYNTHESIS
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_last) |-> (out_char == 8'h00))
    else $error("terminator result carries a nonzero character");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !full)
    else $error("entry pushed into a full queue");

  a_entry_len: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (head.len != 2'd0 && head.len != 2'd3 || head.res[2].last))
    else $error("queue head entry has a bad length");
`endif

endmodule

@@ test/utf8_to_latin1_or_ascii_checker.sv @@
// Checker for the UTF-8 converter: tracks register writes, predicts output characters, compares.
module utf8_to_latin1_or_ascii_checker
  import u2l_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_char,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          chars_due,
  output int          fail_count
);

  // transliteration of U+00C0..U+00FF, indexed by the continuation byte's low six bits
  localparam logic [511:0] C3_XLAT = {"AAAAAAACEEEEIIII", "?NOOOOO?OUUUUY??",
                                      "aaaaaaaceeeeiiii", "?nooooo?ouuuuy?y"};

  result_t     want_chars[$];
  result_t     got;
  logic        mode_r;
  logic [15:0] cap_r;
  logic [1:0]  lead_q;
  logic        skip_cont;
  logic [15:0] char_count;
  int          err_cnt = 0;

  function automatic logic [7:0] ascii_xlat(input logic [1:0] lead, input logic [7:0] b);
    logic [7:0] ch;
    ch = QM;
    if (lead == PL_C3) begin
      if (b[7:6] == 2'b10) ch = C3_XLAT[8 * (63 - b[5:0]) +: 8];
    end else begin
      case (b)
        8'hA9: ch = "C";
        8'hAE: ch = "R";
        8'hB0: ch = "o";
        8'hB1: ch = "+";
        8'hB2: ch = "2";
        8'hB3: ch = "3";
        default: ch = QM;
      endcase
    end
    return ch;
  endfunction

  task automatic put_char(input logic [7:0] ch);
    logic [16:0] lim;
    result_t     r;
    lim = (cap_r == 16'd0) ? 17'd1 : {1'b0, cap_r};
    if ({1'b0, char_count} + 17'd1 < lim) begin
      r.char_val = ch;
      r.last     = 1'b0;
      want_chars.push_back(r);
      char_count = char_count + 16'd1;
    end
  endtask

  task automatic close_string();
    result_t r;
    if (lead_q != PL_NONE) put_char(QM);
    r.char_val = 8'h00;
    r.last     = 1'b1;
    want_chars.push_back(r);
    lead_q     = PL_NONE;
    skip_cont  = 1'b0;
    char_count = 16'd0;
  endtask

  task automatic convert_byte(input logic [7:0] b);
    logic is_cont;
    logic done;
    is_cont = (b[7:6] == 2'b10);
    done    = 1'b0;
    if (!mode_r) begin
      skip_cont = 1'b0;
      if (lead_q != PL_NONE) begin
        put_char(ascii_xlat(lead_q, b));
        lead_q = PL_NONE;
      end else if (!b[7]) begin
        put_char(b);
      end else if (b == LEAD_C2) begin
        lead_q = PL_C2;
      end else if (b == LEAD_C3) begin
        lead_q = PL_C3;
      end else begin
        put_char(QM);
      end
    end else begin
      if (lead_q != PL_NONE) begin
        if (is_cont) begin
          put_char({(lead_q == PL_C3) ? 2'b11 : 2'b10, b[5:0]});
          done = 1'b1;
        end else begin
          put_char(QM);
        end
        lead_q = PL_NONE;
      end
      if (!done && skip_cont) begin
        if (is_cont) done = 1'b1;
        else skip_cont = 1'b0;
      end
      if (!done) begin
        if (!b[7]) begin
          put_char(b);
        end else if (b == LEAD_C2) begin
          lead_q = PL_C2;
        end else if (b == LEAD_C3) begin
          lead_q = PL_C3;
        end else begin
          skip_cont = 1'b1;
          put_char(QM);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_chars.delete();
      mode_r     = 1'b0;
      cap_r      = 16'd64;
      lead_q     = PL_NONE;
      skip_cont  = 1'b0;
      char_count = 16'd0;
    end else begin
      if (pop && !empty) begin
        if (want_chars.size() == 0) begin
          $error("unexpected transaction: out_char %h out_last %b", out_char, out_last);
          err_cnt++;
        end else begin
          got = want_chars.pop_front();
          if (out_char !== got.char_val) begin
            $error("out_char: expected %h, got %h", got.char_val, out_char);
            err_cnt++;
          end
          if (out_last !== got.last) begin
            $error("out_last: expected %b, got %b", got.last, out_last);
            err_cnt++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CAP) cap_r = pwdata[15:0];
        else mode_r = pwdata[0];
      end
      if (push && !full) begin
        if (data_byte == 8'h00) begin
          close_string();
        end else begin
          convert_byte(data_byte);
          if (string_end) close_string();
        end
      end
    end
    chars_due  <= want_chars.size();
    fail_count <= err_cnt;
  end

endmodule

@@ test/tb_utf8_to_latin1_or_ascii_core.sv @@
// Testbench top for the UTF-8 converter: clock, reset, byte and register stimulus, verdict.
module tb_utf8_to_latin1_or_ascii_core;
  import u2l_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        string_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_char;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          chars_due;
  int          fail_count;
  int          bytes_sent = 0;
  int          pop_hold = 0;
  bit          pop_steady = 1'b0;
  bit          send_steady = 1'b0;
  logic [7:0]  seq_q[$];

  utf8_to_latin1_or_ascii_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .string_end(string_end), .empty(empty), .pop(pop), .out_char(out_char),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  utf8_to_latin1_or_ascii_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .string_end(string_end), .empty(empty), .pop(pop), .out_char(out_char),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .chars_due(chars_due), .fail_count(fail_count)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_cap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'd1;
    if (r < 45) return 16'($urandom_range(2, 6));
    if (r < 80) return 16'($urandom_range(7, 64));
    if (r < 90) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // result side: random stalls, with stretches of steady popping
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) pop_steady = !pop_steady;
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
        if (!pop_steady && $urandom_range(0, 3) == 0) pop_hold = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    string_end <= e;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [15:0] cap);
    write_reg(REG_MODE, {31'd0, mode});
    write_reg(REG_CAP, {16'd0, cap});
  endtask

  // wait until every predicted transaction has come out, then idle for slack
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      seq_q.push_back(8'($urandom_range(1, 127)));
    end else if (r < 60) begin
      seq_q.push_back($urandom_range(0, 1) ? LEAD_C3 : LEAD_C2);
      seq_q.push_back(cont_byte());
    end else if (r < 70) begin
      seq_q.push_back(8'($urandom_range(8'hC4, 8'hDF)));
      seq_q.push_back(cont_byte());
    end else if (r < 78) begin
      seq_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      repeat (2) seq_q.push_back(cont_byte());
    end else if (r < 83) begin
      seq_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) seq_q.push_back(cont_byte());
    end else if (r < 88) begin
      seq_q.push_back($urandom_range(0, 1) ? LEAD_C3 : LEAD_C2);
      seq_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 127))
                                           : 8'($urandom_range(8'hC0, 8'hFF)));
    end else if (r < 93) begin
      seq_q.push_back(cont_byte());
    end else begin
      seq_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    int rand_target;
    int n_str;
    int len;
    int style;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // transliteration to ASCII
    set_config(1'b0, 16'd64);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(LEAD_C2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(LEAD_C2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(LEAD_C2, 1'b1);
    settle();

    // Latin-1 output, largest capacity
    set_config(1'b1, 16'hFFFF);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);
    // lead left open across the mode change
    send_byte(LEAD_C3, 1'b0);
    settle();

    // capacity zero: only the terminator comes out
    set_config(1'b0, 16'd0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();

    rand_target = bytes_sent + 190;
    while (bytes_sent < rand_target) begin
      set_config(1'($urandom_range(0, 1)), pick_cap());
      n_str = $urandom_range(2, 6);
      for (int i = 0; i < n_str; i++) begin
        seq_q.delete();
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 10);
        repeat (len) add_char();
        // 0: zero byte closes, 1: end flag on last byte, 2: left open for the next phase
        style = (i == n_str - 1 && $urandom_range(0, 2) == 0) ? 2 : $urandom_range(0, 1);
        if (style == 1 && seq_q.size() == 0) style = 0;
        foreach (seq_q[k]) send_byte(seq_q[k], style == 1 && k == seq_q.size() - 1);
        if (style == 0) send_byte(8'h00, 1'($urandom_range(0, 1)));
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ utf8_to_latin1_or_ascii_core.f @@
rtl/u2l_pkg.sv
rtl/u2l_front.sv
rtl/u2l_fifo.sv
rtl/u2l_back.sv
rtl/utf8_to_latin1_or_ascii_core.sv
test/utf8_to_latin1_or_ascii_checker.sv
test/tb_utf8_to_latin1_or_ascii_core.sv
